/* sv/dss_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dss_pkg: shared types for the DPLL solver
// Command codes, request and result payloads, and the stored literal format.
// ---------------------------------------------------------------------------
package dss_pkg;

  // Variable capacity; the 7-bit variable fields bound it.
  localparam int unsigned MAX_VARS = 64;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] lit_var;
    logic       lit_negated;
    logic       clause_end;
  } req_t;

  typedef struct packed {
    logic [6:0]  var_index;
    logic        var_value;
    logic        satisfiable;
    logic        store_overflow;
    logic [31:0] decision_count;
    logic [31:0] propagation_count;
    logic [31:0] conflict_count;
    logic        last;
  } res_t;

  // One literal as kept in the formula store.
  typedef struct packed {
    logic       clause_end;
    logic       lit_negated;
    logic [6:0] lit_var;
  } lit_t;

endpackage
`default_nettype wire

/* sv/dss_lit_store.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dss_lit_store: formula literal memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dss_lit_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire dss_pkg::lit_t  wdata_i,
  input  wire logic [AW-1:0]  raddr_i,
  output dss_pkg::lit_t       rdata_o
);

  dss_pkg::lit_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/dpll_sat_solver_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dpll_sat_solver_core: CNF store with a DPLL search engine
// Loads literals, then searches for a satisfying assignment on request.
// ---------------------------------------------------------------------------
// A load or clear request is handled without leaving idle, so loads stream
// at one per cycle while no solve is running. A solve request holds busy
// high for the length of the search: each propagation pass reads the
// literal store once, per literal a literal read, then a value read of its
// variable; a branch scans the assigned flags one variable per cycle;
// backtracking undoes the trail one entry at a time (trail read, then flag
// clear). Results then come out one item at a time (value memory read, then
// capture). The receiver cannot stall: each result is on res_o for exactly
// one cycle with res_strobe_o high. The literal store needs no clearing
// pass after reset; a clause that runs past MAX_LITERALS or MAX_CLAUSES is
// dropped whole, and store_overflow stays set until a clear request.
// ---------------------------------------------------------------------------
module dpll_sat_solver_core #(
  parameter int unsigned MAX_LITERALS = 1024,
  parameter int unsigned MAX_CLAUSES  = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire dss_pkg::req_t req_i,
  output logic               res_strobe_o,
  output dss_pkg::res_t      res_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [6:0]    cfg_data_i
);

  localparam int unsigned MAX_VARS = dss_pkg::MAX_VARS;
  localparam int unsigned AW  = $clog2(MAX_LITERALS);
  localparam int unsigned LW  = $clog2(MAX_LITERALS + 1);
  localparam int unsigned CW  = $clog2(MAX_CLAUSES + 1);
  localparam int unsigned VW  = $clog2(MAX_VARS + 1);
  localparam int unsigned IW  = $clog2(MAX_VARS);
  localparam int unsigned TW  = $clog2(MAX_VARS + 1);
  localparam int unsigned SKW = 1 + TW + VW;

  typedef enum logic [3:0] {
    S_IDLE, S_PSTART, S_VAR, S_EVAL, S_DEC,
    S_BT0, S_BT1, S_UNDO, S_UNDO2, S_OUT_RD, S_OUT_CAP
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Control and working registers
  state_e             state_q, state_d;
  logic               strobe_q, strobe_d;
  dss_pkg::res_t      res_q, res_d;
  logic [LW-1:0]      fill_q, fill_d, open_q, open_d;
  logic [CW-1:0]      cls_q, cls_d;
  logic               disc_q, disc_d, ovf_q, ovf_d;
  logic [6:0]         nvars_q, nvars_d, n_q, n_d;
  logic [AW-1:0]      idx_q, idx_d;
  dss_pkg::lit_t      lit_q, lit_d, unit_q, unit_d;
  logic               csat_q, csat_d, changed_q, changed_d, allsat_q, allsat_d;
  logic [1:0]         unas_q, unas_d;
  logic [VW-1:0]      u_q, u_d;
  logic [MAX_VARS:0]  asg_q, asg_d;
  logic [TW-1:0]      tlen_q, tlen_d, slen_q, slen_d;
  logic [SKW-1:0]     top_q, top_d;
  logic [31:0]        dec_q, dec_d, prop_q, prop_d, conf_q, conf_d;

  // Memory ports
  logic               lit_we;
  logic [AW-1:0]      lit_waddr, lit_raddr;
  dss_pkg::lit_t      lit_wdata, lit_rdata;
  logic [VW-1:0]      val_raddr;
  logic               val_rdata_q;
  logic [IW-1:0]      tr_raddr, sk_raddr, sk_waddr;
  logic [VW-1:0]      tr_rdata_q;
  logic               sk_we;
  logic [SKW-1:0]     sk_wdata, sk_rdata_q;

  // Assignment port shared by unit, branch and flip
  logic               asn_en, asn_val;
  logic [VW-1:0]      asn_var;

  logic               val_mem [MAX_VARS+1];
  logic [VW-1:0]      trail_mem [MAX_VARS];
  logic [SKW-1:0]     stack_mem [MAX_VARS];

  // Literal evaluation helpers
  logic               lvalid, ev_true, ev_un, csat_n, asg_now, ch_n, as_n, full;
  logic [1:0]         unas_n;
  dss_pkg::lit_t      unit_n;
  logic [VW-1:0]      lvar, nvw;
  logic [TW-1:0]      top_mark;
  logic [VW-1:0]      top_var;
  logic               top_phase;

  assign busy         = (state_q != S_IDLE);
  assign cfg_ready_o  = (state_q == S_IDLE);
  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

  assign nvw       = VW'(n_q);
  assign lvar      = VW'(lit_q.lit_var);
  assign lvalid    = (lit_q.lit_var != 7'd0) && (lit_q.lit_var <= n_q);
  assign ev_true   = lvalid && asg_q[lvar] && (val_rdata_q ^ lit_q.lit_negated);
  assign ev_un     = lvalid && !asg_q[lvar];
  assign csat_n    = csat_q | ev_true;
  assign unas_n    = ev_un ? ((unas_q == 2'd0) ? 2'd1 : 2'd2) : unas_q;
  assign unit_n    = ev_un ? lit_q : unit_q;
  assign asg_now   = !csat_n && (unas_n == 2'd1);
  assign ch_n      = changed_q | asg_now;
  assign as_n      = allsat_q & csat_n;
  assign full      = (fill_q >= LW'(MAX_LITERALS)) || (cls_q >= CW'(MAX_CLAUSES));
  assign top_var   = top_q[VW-1:0];
  assign top_mark  = top_q[VW+TW-1:VW];
  assign top_phase = top_q[SKW-1];

  dss_lit_store #(
    .DEPTH (MAX_LITERALS),
    .AW    (AW)
  ) u_lit_store (
    .clk_i   (clk_i),
    .we_i    (lit_we),
    .waddr_i (lit_waddr),
    .wdata_i (lit_wdata),
    .raddr_i (lit_raddr),
    .rdata_o (lit_rdata)
  );

  always_comb begin
    state_d   = state_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    fill_d    = fill_q;
    open_d    = open_q;
    cls_d     = cls_q;
    disc_d    = disc_q;
    ovf_d     = ovf_q;
    nvars_d   = nvars_q;
    n_d       = n_q;
    idx_d     = idx_q;
    lit_d     = lit_q;
    unit_d    = unit_q;
    csat_d    = csat_q;
    unas_d    = unas_q;
    changed_d = changed_q;
    allsat_d  = allsat_q;
    u_d       = u_q;
    asg_d     = asg_q;
    tlen_d    = tlen_q;
    slen_d    = slen_q;
    top_d     = top_q;
    dec_d     = dec_q;
    prop_d    = prop_q;
    conf_d    = conf_q;
    lit_we    = 1'b0;
    lit_waddr = AW'(fill_q);
    lit_wdata = '{clause_end: req_i.clause_end, lit_negated: req_i.lit_negated,
                  lit_var: req_i.lit_var};
    lit_raddr = '0;
    val_raddr = lvar;
    tr_raddr  = IW'(tlen_q - TW'(1));
    sk_raddr  = IW'(slen_q - TW'(1));
    sk_we     = 1'b0;
    sk_waddr  = IW'(slen_q);
    sk_wdata  = {1'b0, tlen_q, u_q};
    asn_en    = 1'b0;
    asn_var   = u_q;
    asn_val   = 1'b1;

    if (cfg_valid_i && cfg_ready_o) begin
      nvars_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_i.cmd)
            dss_pkg::CMD_LOAD: begin
              if (disc_q || full) begin
                // drop the literal and its whole clause
                if (!disc_q) begin
                  ovf_d  = 1'b1;
                  fill_d = open_q;
                end
                disc_d = !req_i.clause_end;
              end else begin
                lit_we = 1'b1;
                fill_d = fill_q + LW'(1);
                if (req_i.clause_end) begin
                  cls_d  = cls_q + CW'(1);
                  open_d = fill_q + LW'(1);
                end
              end
            end
            dss_pkg::CMD_SOLVE: begin
              asg_d   = '0;
              tlen_d  = '0;
              slen_d  = '0;
              dec_d   = '0;
              prop_d  = '0;
              conf_d  = '0;
              n_d     = (nvars_q > 7'(MAX_VARS)) ? 7'(MAX_VARS) : nvars_q;
              state_d = S_PSTART;
            end
            dss_pkg::CMD_CLEAR: begin
              fill_d = '0;
              open_d = '0;
              cls_d  = '0;
              disc_d = 1'b0;
              ovf_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_PSTART: begin
        changed_d = 1'b0;
        allsat_d  = 1'b1;
        csat_d    = 1'b0;
        unas_d    = 2'd0;
        idx_d     = '0;
        if (open_q == '0) begin
          // empty formula: every clause holds
          if (n_q == 7'd0) begin
            res_d    = '{var_index: 7'd0, var_value: 1'b0, satisfiable: 1'b1,
                         store_overflow: ovf_q, decision_count: dec_q,
                         propagation_count: prop_q, conflict_count: conf_q,
                         last: 1'b1};
            strobe_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            u_d     = VW'(1);
            state_d = S_OUT_RD;
          end
        end else begin
          lit_raddr = '0;
          state_d   = S_VAR;
        end
      end

      S_VAR: begin
        lit_d     = lit_rdata;
        val_raddr = VW'(lit_rdata.lit_var);
        state_d   = S_EVAL;
      end

      S_EVAL: begin
        if (!lit_q.clause_end) begin
          csat_d    = csat_n;
          unas_d    = unas_n;
          unit_d    = unit_n;
          idx_d     = idx_q + AW'(1);
          lit_raddr = idx_q + AW'(1);
          state_d   = S_VAR;
        end else begin
          csat_d = 1'b0;
          unas_d = 2'd0;
          if (!csat_n && (unas_n == 2'd0)) begin
            // every literal false
            conf_d  = sat_inc(conf_q);
            state_d = S_BT0;
          end else begin
            if (asg_now) begin
              asn_en  = 1'b1;
              asn_var = VW'(unit_n.lit_var);
              asn_val = !unit_n.lit_negated;
              prop_d  = sat_inc(prop_q);
            end
            if ((LW'(idx_q) + LW'(1)) == open_q) begin
              if (ch_n) begin
                state_d = S_PSTART;
              end else if (as_n) begin
                if (n_q == 7'd0) begin
                  res_d    = '{var_index: 7'd0, var_value: 1'b0, satisfiable: 1'b1,
                               store_overflow: ovf_q, decision_count: dec_q,
                               propagation_count: prop_q, conflict_count: conf_q,
                               last: 1'b1};
                  strobe_d = 1'b1;
                  state_d  = S_IDLE;
                end else begin
                  u_d     = VW'(1);
                  state_d = S_OUT_RD;
                end
              end else begin
                u_d     = VW'(1);
                state_d = S_DEC;
              end
            end else begin
              changed_d = ch_n;
              allsat_d  = as_n;
              idx_d     = idx_q + AW'(1);
              lit_raddr = idx_q + AW'(1);
              state_d   = S_VAR;
            end
          end
        end
      end

      S_DEC: begin
        if ((n_q == 7'd0) || (slen_q == TW'(MAX_VARS))) begin
          state_d = S_BT0;
        end else if (!asg_q[u_q]) begin
          // push a decision on the first free variable, true first
          sk_we   = 1'b1;
          slen_d  = slen_q + TW'(1);
          dec_d   = sat_inc(dec_q);
          asn_en  = 1'b1;
          state_d = S_PSTART;
        end else if (u_q == nvw) begin
          state_d = S_BT0;
        end else begin
          u_d = u_q + VW'(1);
        end
      end

      S_BT0: begin
        if (slen_q == '0) begin
          res_d    = '{var_index: 7'd0, var_value: 1'b0, satisfiable: 1'b0,
                       store_overflow: ovf_q, decision_count: dec_q,
                       propagation_count: prop_q, conflict_count: conf_q,
                       last: 1'b1};
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_BT1;
        end
      end

      S_BT1: begin
        top_d   = sk_rdata_q;
        state_d = S_UNDO;
      end

      S_UNDO: begin
        if (tlen_q > top_mark) begin
          tlen_d  = tlen_q - TW'(1);
          state_d = S_UNDO2;
        end else if (!top_phase) begin
          // flip the decision to false
          sk_we    = 1'b1;
          sk_waddr = IW'(slen_q - TW'(1));
          sk_wdata = {1'b1, top_mark, top_var};
          asn_en   = 1'b1;
          asn_var  = top_var;
          asn_val  = 1'b0;
          state_d  = S_PSTART;
        end else begin
          slen_d  = slen_q - TW'(1);
          state_d = S_BT0;
        end
      end

      S_UNDO2: begin
        asg_d[tr_rdata_q] = 1'b0;
        state_d           = S_UNDO;
      end

      S_OUT_RD: begin
        val_raddr = u_q;
        state_d   = S_OUT_CAP;
      end

      S_OUT_CAP: begin
        res_d    = '{var_index: 7'(u_q), var_value: asg_q[u_q] & val_rdata_q,
                     satisfiable: 1'b1, store_overflow: ovf_q,
                     decision_count: dec_q, propagation_count: prop_q,
                     conflict_count: conf_q, last: (u_q == nvw)};
        strobe_d = 1'b1;
        if (u_q == nvw) begin
          state_d = S_IDLE;
        end else begin
          u_d     = u_q + VW'(1);
          state_d = S_OUT_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (asn_en) begin
      asg_d[asn_var] = 1'b1;
      if (tlen_q != TW'(MAX_VARS)) begin
        tlen_d = tlen_q + TW'(1);
      end
    end
  end

  // Assignment value, trail and decision stack memories
  always_ff @(posedge clk_i) begin
    if (asn_en) begin
      val_mem[asn_var] <= asn_val;
      if (tlen_q != TW'(MAX_VARS)) begin
        trail_mem[IW'(tlen_q)] <= asn_var;
      end
    end
    val_rdata_q <= val_mem[val_raddr];
    tr_rdata_q  <= trail_mem[tr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sk_we) begin
      stack_mem[sk_waddr] <= sk_wdata;
    end
    sk_rdata_q <= stack_mem[sk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      strobe_q  <= 1'b0;
      res_q     <= '0;
      fill_q    <= '0;
      open_q    <= '0;
      cls_q     <= '0;
      disc_q    <= 1'b0;
      ovf_q     <= 1'b0;
      nvars_q   <= 7'd1;
      n_q       <= '0;
      idx_q     <= '0;
      lit_q     <= '0;
      unit_q    <= '0;
      csat_q    <= 1'b0;
      unas_q    <= 2'd0;
      changed_q <= 1'b0;
      allsat_q  <= 1'b0;
      u_q       <= '0;
      asg_q     <= '0;
      tlen_q    <= '0;
      slen_q    <= '0;
      top_q     <= '0;
      dec_q     <= '0;
      prop_q    <= '0;
      conf_q    <= '0;
    end else begin
      state_q   <= state_d;
      strobe_q  <= strobe_d;
      res_q     <= res_d;
      fill_q    <= fill_d;
      open_q    <= open_d;
      cls_q     <= cls_d;
      disc_q    <= disc_d;
      ovf_q     <= ovf_d;
      nvars_q   <= nvars_d;
      n_q       <= n_d;
      idx_q     <= idx_d;
      lit_q     <= lit_d;
      unit_q    <= unit_d;
      csat_q    <= csat_d;
      unas_q    <= unas_d;
      changed_q <= changed_d;
      allsat_q  <= allsat_d;
      u_q       <= u_d;
      asg_q     <= asg_d;
      tlen_q    <= tlen_d;
      slen_q    <= slen_d;
      top_q     <= top_d;
      dec_q     <= dec_d;
      prop_q    <= prop_d;
      conf_q    <= conf_d;
    end
  end

endmodule
`default_nettype wire

/* sim/dpll_sat_solver_core_tb.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dpll_sat_solver_core_tb: self-checking regression for the DPLL solver
// Streams literal loads, clears and solve requests under several idling
// phases and num_vars settings, predicts every solve outcome with a
// behavioral DPLL search, and compares each result item field by field.
// ---------------------------------------------------------------------------
module dpll_sat_solver_core_tb;

  localparam int unsigned NV_CAP   = 64;
  localparam int unsigned LIT_CAP  = 1024;
  localparam int unsigned CLS_CAP  = 256;
  localparam int unsigned IDLE_LIM = 20000000;

  // Value codes of the predictor's assignment table.
  localparam logic [1:0] V_FREE = 2'd0;
  localparam logic [1:0] V_TRUE = 2'd1;
  localparam logic [1:0] V_FALS = 2'd2;

  // Behavioral solver and pending-result store.
  class solve_scoreboard;
    dss_pkg::lit_t formula [LIT_CAP];
    int unsigned fill, clauses, open_at;
    bit          dropping, overflow;
    int unsigned nvars;
    int unsigned nlim;
    logic [1:0]  value [NV_CAP+1];
    int unsigned trail [NV_CAP];
    int unsigned trail_len;
    int unsigned dvar [NV_CAP];
    int unsigned dmark [NV_CAP];
    bit          dphase [NV_CAP];
    int unsigned depth;
    logic [31:0] n_dec, n_prop, n_conf;
    dss_pkg::res_t pending [$];
    int unsigned errors, checked, solves, sat_solves;

    function new();
      fill = 0; clauses = 0; open_at = 0; dropping = 0; overflow = 0;
      nvars = 1; nlim = 1; errors = 0; checked = 0; solves = 0; sat_solves = 0;
    endfunction

    function void bump(ref logic [31:0] c);
      if (c != 32'hFFFF_FFFF) c++;
    endfunction

    function logic [1:0] lit_state(dss_pkg::lit_t l);
      if (l.lit_var == 0 || l.lit_var > nlim) return V_FALS;
      if (value[l.lit_var] == V_FREE) return V_FREE;
      return ((value[l.lit_var] == V_TRUE) != l.lit_negated) ? V_TRUE : V_FALS;
    endfunction

    function int unsigned clause_tail(int unsigned i);
      while (i + 1 < open_at && !formula[i].clause_end) i++;
      return i;
    endfunction

    function void set_var(int unsigned v, logic [1:0] x);
      if (v == 0 || v > NV_CAP) return;
      value[v] = x;
      if (trail_len < NV_CAP) begin
        trail[trail_len] = v;
        trail_len++;
      end
    endfunction

    // Unit propagation to a fixed point; 0 on conflict.
    function bit propagate_units();
      bit changed;
      int unsigned i, j, free_n;
      bit sat;
      dss_pkg::lit_t unit;
      changed = 1;
      while (changed) begin
        changed = 0;
        i = 0;
        while (i < open_at) begin
          j = clause_tail(i);
          sat = 0; free_n = 0; unit = '0;
          for (int unsigned k = i; k <= j; k++)
            if (lit_state(formula[k]) == V_TRUE) sat = 1;
          if (!sat) begin
            for (int unsigned k = i; k <= j; k++)
              if (lit_state(formula[k]) == V_FREE) begin
                free_n++;
                unit = formula[k];
              end
            if (free_n == 0) begin
              bump(n_conf);
              return 0;
            end
            if (free_n == 1) begin
              set_var(unit.lit_var, unit.lit_negated ? V_FALS : V_TRUE);
              bump(n_prop);
              changed = 1;
            end
          end
          i = j + 1;
        end
      end
      return 1;
    endfunction

    function bit all_satisfied();
      int unsigned i, j;
      bit sat;
      i = 0;
      while (i < open_at) begin
        j = clause_tail(i);
        sat = 0;
        for (int unsigned k = i; k <= j; k++)
          if (lit_state(formula[k]) == V_TRUE) sat = 1;
        if (!sat) return 0;
        i = j + 1;
      end
      return 1;
    endfunction

    function bit dpll_search();
      bit ok;
      int unsigned v;
      forever begin
        ok = propagate_units();
        if (ok) begin
          if (all_satisfied()) return 1;
          v = 0;
          for (int unsigned u = nlim; u >= 1; u--)
            if (value[u] == V_FREE) v = u;
          if (v == 0 || depth >= NV_CAP) ok = 0;
          else begin
            bump(n_dec);
            dvar[depth] = v; dmark[depth] = trail_len; dphase[depth] = 0;
            depth++;
            set_var(v, V_TRUE);
          end
        end
        if (!ok) begin
          forever begin
            if (depth == 0) return 0;
            while (trail_len > dmark[depth-1]) begin
              trail_len--;
              value[trail[trail_len]] = V_FREE;
            end
            if (!dphase[depth-1]) begin
              dphase[depth-1] = 1;
              set_var(dvar[depth-1], V_FALS);
              break;
            end
            depth--;
          end
        end
      end
    endfunction

    function void push_result(int unsigned idx, bit val, bit sat, bit fin);
      dss_pkg::res_t r;
      r.var_index = idx[6:0]; r.var_value = val; r.satisfiable = sat;
      r.store_overflow = overflow; r.decision_count = n_dec;
      r.propagation_count = n_prop; r.conflict_count = n_conf; r.last = fin;
      pending.insert(pending.size(), r);
    endfunction

    // Note an accepted request and queue the results it causes.
    function void note_request(dss_pkg::req_t q);
      int unsigned n;
      bit sat;
      case (q.cmd)
        dss_pkg::CMD_LOAD: begin
          if (!dropping && (fill >= LIT_CAP || clauses >= CLS_CAP)) begin
            overflow = 1; dropping = 1; fill = open_at;
          end
          if (dropping) begin
            if (q.clause_end) dropping = 0;
          end else begin
            formula[fill] = {q.clause_end, q.lit_negated, q.lit_var};
            fill++;
            if (q.clause_end) begin
              clauses++;
              open_at = fill;
            end
          end
        end
        dss_pkg::CMD_CLEAR: begin
          fill = 0; clauses = 0; open_at = 0; dropping = 0; overflow = 0;
        end
        dss_pkg::CMD_SOLVE: begin
          n = nvars < NV_CAP ? nvars : NV_CAP;
          nlim = n;
          foreach (value[i]) value[i] = V_FREE;
          trail_len = 0; depth = 0; n_dec = 0; n_prop = 0; n_conf = 0;
          sat = dpll_search();
          solves++;
          if (sat) sat_solves++;
          if (!sat || n == 0) push_result(0, 0, sat, 1);
          else
            for (int unsigned v = 1; v <= n; v++)
              push_result(v, value[v] == V_TRUE, 1, v == n);
        end
        default: ;
      endcase
    endfunction

    function void check_result(dss_pkg::res_t got);
      dss_pkg::res_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  dss_pkg::req_t req_i = '0;
  logic          res_strobe_o;
  dss_pkg::res_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [6:0]    cfg_data_i = '0;

  solve_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     cycle_cnt = 0;

  always #6 clk_i = ~clk_i;

  dpll_sat_solver_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Sample results and accepted requests at the edge; the predictor runs
  // on the values that were stable before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (res_strobe_o) sb.check_result(res_o);
      if (start && !busy) sb.note_request(req_i);
      if (res_strobe_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIM) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIM);
        $display("dpll_sat_solver_core regression: fail");
        $finish;
      end
    end
  end

  // Issue one request; hold start until the block accepts it, then drop it
  // only when an idle gap follows.
  task automatic send_request(dss_pkg::req_t q);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_lit(int unsigned v, bit neg, bit fin);
    dss_pkg::req_t q;
    q.cmd = dss_pkg::CMD_LOAD; q.lit_var = v[6:0]; q.lit_negated = neg;
    q.clause_end = fin;
    send_request(q);
  endtask

  task automatic issue_cmd(dss_pkg::cmd_e c);
    dss_pkg::req_t q;
    q = '0;
    q.cmd = c;
    q.lit_var = 7'($urandom);
    q.lit_negated = 1'($urandom);
    q.clause_end = 1'($urandom);
    send_request(q);
  endtask

  // Wait for all results, then let the block settle before a register write.
  task automatic drain();
    drop_start();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_num_vars(int unsigned n);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n[6:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.nvars = {25'd0, n[6:0]};
    @(posedge clk_i);
  endtask

  // Random formula of small clauses over 1..nv, with a few out-of-range
  // variables mixed in; occasionally leave the last clause open.
  task automatic random_formula(int unsigned nv, int unsigned ncl,
                                output int unsigned cnt);
    int unsigned len;
    cnt = 2;
    issue_cmd(dss_pkg::CMD_CLEAR);
    for (int unsigned c = 0; c < ncl; c++) begin
      len = $urandom_range(3, 1);
      cnt += len;
      for (int unsigned k = 0; k < len; k++)
        load_lit(($urandom_range(19, 0) == 0) ? $urandom_range(127, 0)
                                              : $urandom_range(nv, 1),
                 1'($urandom), k == len - 1);
    end
    if ($urandom_range(7, 0) == 0) begin
      load_lit($urandom_range(nv, 1), 1'($urandom), 0);
      cnt++;
    end
    issue_cmd(dss_pkg::CMD_SOLVE);
  endtask

  task automatic random_phase(int unsigned nv, int unsigned items);
    int unsigned sent, cnt;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9, 0))
        0: begin
          // noise: stray commands, including the unused code
          issue_cmd(dss_pkg::cmd_e'($urandom_range(3, 0)));
          sent++;
        end
        default: begin
          random_formula(nv, $urandom_range(nv + 3, 1), cnt);
          sent += cnt;
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty formula, single unit, direct contradiction, field extremes.
    issue_cmd(dss_pkg::CMD_SOLVE);
    write_num_vars(0);
    issue_cmd(dss_pkg::CMD_SOLVE);
    write_num_vars(3);
    load_lit(2, 1, 1);
    load_lit(0, 0, 0);
    load_lit(127, 1, 0);
    load_lit(64, 0, 1);
    issue_cmd(dss_pkg::CMD_SOLVE);
    load_lit(1, 0, 1);
    load_lit(1, 1, 1);
    load_lit(3, 0, 0);
    issue_cmd(dss_pkg::CMD_SOLVE);
    issue_cmd(dss_pkg::cmd_e'(2'd3));
    issue_cmd(dss_pkg::CMD_CLEAR);
    load_lit(1, 0, 0);
    load_lit(2, 0, 1);
    load_lit(1, 1, 0);
    load_lit(3, 1, 1);
    issue_cmd(dss_pkg::CMD_SOLVE);
    write_num_vars(64);
    issue_cmd(dss_pkg::CMD_SOLVE);
    write_num_vars(127);
    issue_cmd(dss_pkg::CMD_SOLVE);

    // Overflow: clear, fill the store past the clause limit, then solve.
    write_num_vars(8);
    issue_cmd(dss_pkg::CMD_CLEAR);
    for (int unsigned c = 0; c < CLS_CAP + 3; c++)
      load_lit($urandom_range(8, 1), 1'($urandom), 1);
    load_lit(1, 0, 0);
    load_lit(2, 0, 1);
    issue_cmd(dss_pkg::CMD_SOLVE);

    // Random phases under varying sender idling and register settings.
    send_idle_pct = 0;  write_num_vars(4);  random_phase(4, 50);
    send_idle_pct = 81; write_num_vars(6);  random_phase(6, 50);
    send_idle_pct = 6;  write_num_vars(1);  random_phase(1, 30);
    send_idle_pct = 0;  write_num_vars(10); random_phase(10, 50);
    send_idle_pct = 81; write_num_vars(64); random_phase(8, 30);

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d solves (%0d satisfiable), %0d result items checked",
             sb.solves, sb.sat_solves, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("dpll_sat_solver_core regression: pass");
    else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("dpll_sat_solver_core regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
